### design/tank_fill_drain_sequencer_top_macros.svh
// assertion helpers for the tank fill/drain sequencer
`ifndef TANK_FILL_DRAIN_SEQUENCER_TOP_MACROS_SVH
`define TANK_FILL_DRAIN_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TFDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TFDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tfds_pkg.sv
// ----------------------------------------------------------------------------
// tfds_pkg
// types and constants shared by the tank fill/drain sequencer
// ----------------------------------------------------------------------------
package tfds_pkg;

    typedef enum logic [2:0] {
        MODE_RECIRC     = 3'd0,
        MODE_WAIT_FILL  = 3'd1,
        MODE_FILLING    = 3'd2,
        MODE_HOLDING    = 3'd3,
        MODE_WAIT_DRAIN = 3'd4,
        MODE_DRAINING   = 3'd5,
        MODE_ERR_UPPER  = 3'd6,
        MODE_ERR_LOWER  = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        OP_LEVELS      = 4'd0,
        OP_SVC_FILL    = 4'd1,
        OP_SVC_DRAIN   = 4'd2,
        OP_IDLE_CHECK  = 4'd3,
        OP_QUEUE_FILL  = 4'd4,
        OP_QUEUE_DRAIN = 4'd5,
        OP_START_FILL  = 4'd6,
        OP_START_DRAIN = 4'd7,
        OP_CLEAR       = 4'd8,
        OP_MAN_FILL    = 4'd9,
        OP_MAN_DRAIN   = 4'd10
    } op_t;

    localparam logic [1:0] CFG_FILL_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_DRAIN_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_HOLD_TIME     = 2'd2;

    localparam logic [31:0] FILL_TIMEOUT_RST  = 32'd60000;
    localparam logic [31:0] DRAIN_TIMEOUT_RST = 32'd60000;
    localparam logic [31:0] HOLD_TIME_RST     = 32'd300000;

    typedef struct packed {
        logic [31:0] fill_timeout;
        logic [31:0] drain_timeout;
        logic [31:0] hold_time;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic        fill_open;
        logic        drain_open;
        logic [31:0] fill_time;
        logic [31:0] drain_time;
        logic [31:0] hold_start;
        logic        upper_err;
        logic        lower_err;
        logic        upper_level;
        logic        lower_level;
    } state_t;

    typedef struct packed {
        mode_t mode;
        logic  fill_valve;
        logic  drain_valve;
        logic  upper_error;
        logic  lower_error;
        logic  wants_fill;
        logic  wants_drain;
    } status_t;

endpackage

### design/tank_fill_drain_sequencer_top.sv
// ----------------------------------------------------------------------------
// tank_fill_drain_sequencer_top: fill/drain sequencer for one vessel
// path: the input register holds each accepted item, the result register holds its status item
// throughput: one item per cycle while out_stall does not hold the result register
// reset: async active low, mode recirc, valves shut, flags clear, timers 0
// ----------------------------------------------------------------------------
`include "tank_fill_drain_sequencer_top_macros.svh"

module tank_fill_drain_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic        upper_wet,
    input  logic        lower_wet,
    input  logic        valve_on,

    // status item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  mode,
    output logic        fill_valve,
    output logic        drain_valve,
    output logic        upper_error,
    output logic        lower_error,
    output logic        wants_fill,
    output logic        wants_drain
);

    tfds_pkg::cfg_t    cfg;
    tfds_pkg::state_t  state_reg;
    tfds_pkg::state_t  state_next;
    tfds_pkg::status_t status_next;
    tfds_pkg::status_t status_reg;

    // input register: holds one item until the update stage takes it
    logic        in_valid_reg;
    logic [3:0]  opcode_reg;
    logic [31:0] now_reg;
    logic        upper_wet_reg;
    logic        lower_wet_reg;
    logic        valve_on_reg;

    logic        out_valid_reg;
    logic        out_free;
    logic        advance;
    logic        load_in;

    // result register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // the registered item updates the state and moves into the result register
    assign advance  = in_valid_reg && out_free;
    // input register refills as it drains, so items can follow back to back
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    tfds_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tfds_step u_step
    (
        .opcode    (opcode_reg),
        .now_ms    (now_reg),
        .upper_wet (upper_wet_reg),
        .lower_wet (lower_wet_reg),
        .valve_on  (valve_on_reg),
        .cfg       (cfg),
        .cur       (state_reg),
        .nxt       (state_next),
        .status    (status_next)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load_in)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // input stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            opcode_reg    <= opcode;
            now_reg       <= now_ms;
            upper_wet_reg <= upper_wet;
            lower_wet_reg <= lower_wet;
            valve_on_reg  <= valve_on;
        end
    end

    // vessel state, committed once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= tfds_pkg::MODE_RECIRC;
            state_reg.fill_open   <= 1'b0;
            state_reg.drain_open  <= 1'b0;
            state_reg.fill_time   <= 32'd0;
            state_reg.drain_time  <= 32'd0;
            state_reg.hold_start  <= 32'd0;
            state_reg.upper_err   <= 1'b0;
            state_reg.lower_err   <= 1'b0;
            state_reg.upper_level <= 1'b0;
            state_reg.lower_level <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
            status_reg <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign mode        = status_reg.mode;
    assign fill_valve  = status_reg.fill_valve;
    assign drain_valve = status_reg.drain_valve;
    assign upper_error = status_reg.upper_error;
    assign lower_error = status_reg.lower_error;
    assign wants_fill  = status_reg.wants_fill;
    assign wants_drain = status_reg.wants_drain;

    // an error mode is always backed by its latched flag
    `TFDS_ASSERT_NOW(a_err_upper_flag, state_reg.mode == tfds_pkg::MODE_ERR_UPPER, state_reg.upper_err, "upper error mode without flag")
    `TFDS_ASSERT_NOW(a_err_lower_flag, state_reg.mode == tfds_pkg::MODE_ERR_LOWER, state_reg.lower_err, "lower error mode without flag")
    // requests are never raised with an error latched or a valve open
    `TFDS_ASSERT_NOW(a_want_blocked, out_valid && (wants_fill || wants_drain), !upper_error && !lower_error && !fill_valve && !drain_valve, "request while blocked")
    // state only moves when an item enters the result register
    `TFDS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_reg), "state changed without an item")

endmodule

### design/tfds_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfds_cfg_regs
// timeout and hold time registers, written through the plain write port
// ----------------------------------------------------------------------------
module tfds_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output tfds_pkg::cfg_t      cfg
);

    tfds_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_timeout  <= tfds_pkg::FILL_TIMEOUT_RST;
            cfg_reg.drain_timeout <= tfds_pkg::DRAIN_TIMEOUT_RST;
            cfg_reg.hold_time     <= tfds_pkg::HOLD_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tfds_pkg::CFG_FILL_TIMEOUT:  cfg_reg.fill_timeout  <= cfg_data;
                tfds_pkg::CFG_DRAIN_TIMEOUT: cfg_reg.drain_timeout <= cfg_data;
                tfds_pkg::CFG_HOLD_TIME:     cfg_reg.hold_time     <= cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/tfds_step.sv
// ----------------------------------------------------------------------------
// tfds_step
// next vessel state and status for one item, pure combinational
// ----------------------------------------------------------------------------
module tfds_step
(
    input  logic [3:0]          opcode,
    input  logic [31:0]         now_ms,
    input  logic                upper_wet,
    input  logic                lower_wet,
    input  logic                valve_on,
    input  tfds_pkg::cfg_t      cfg,
    input  tfds_pkg::state_t    cur,
    output tfds_pkg::state_t    nxt,
    output tfds_pkg::status_t   status
);

    logic        any_err;
    logic [31:0] fill_elapsed;
    logic [31:0] drain_elapsed;
    logic [31:0] hold_elapsed;
    logic        blocked;

    assign any_err       = cur.upper_err | cur.lower_err;
    assign fill_elapsed  = now_ms - cur.fill_time;
    assign drain_elapsed = now_ms - cur.drain_time;

    always_comb
    begin
        nxt = cur;
        unique case (opcode)
            tfds_pkg::OP_LEVELS:
            begin
                nxt.upper_level = upper_wet;
                nxt.lower_level = lower_wet;
            end
            tfds_pkg::OP_SVC_FILL:
            begin
                if (cur.fill_open)
                begin
                    if (cur.upper_level && cur.lower_level)
                    begin
                        nxt.fill_open  = 1'b0;
                        nxt.mode       = tfds_pkg::MODE_HOLDING;
                        nxt.hold_start = now_ms;
                    end
                    else if (fill_elapsed >= cfg.fill_timeout && !cur.upper_level)
                    begin
                        nxt.fill_open = 1'b0;
                        nxt.upper_err = 1'b1;
                        nxt.mode      = tfds_pkg::MODE_ERR_UPPER;
                    end
                end
            end
            tfds_pkg::OP_SVC_DRAIN:
            begin
                if (cur.drain_open)
                begin
                    if (!cur.upper_level && !cur.lower_level)
                    begin
                        nxt.drain_open = 1'b0;
                        nxt.mode       = tfds_pkg::MODE_RECIRC;
                    end
                    else if (drain_elapsed >= cfg.drain_timeout && cur.lower_level)
                    begin
                        nxt.drain_open = 1'b0;
                        nxt.lower_err  = 1'b1;
                        nxt.mode       = tfds_pkg::MODE_ERR_LOWER;
                    end
                end
            end
            tfds_pkg::OP_IDLE_CHECK:
            begin
                if (!cur.fill_open && !cur.drain_open && !any_err)
                begin
                    if (cur.upper_level && !cur.lower_level)
                    begin
                        nxt.lower_err = 1'b1;
                        nxt.mode      = tfds_pkg::MODE_ERR_LOWER;
                    end
                    else if (cur.mode == tfds_pkg::MODE_RECIRC &&
                             cur.upper_level && cur.lower_level)
                    begin
                        nxt.mode       = tfds_pkg::MODE_HOLDING;
                        nxt.hold_start = now_ms;
                    end
                end
            end
            tfds_pkg::OP_QUEUE_FILL:
            begin
                if (cur.mode == tfds_pkg::MODE_RECIRC || cur.mode == tfds_pkg::MODE_HOLDING)
                    nxt.mode = tfds_pkg::MODE_WAIT_FILL;
            end
            tfds_pkg::OP_QUEUE_DRAIN:
            begin
                if (cur.mode == tfds_pkg::MODE_HOLDING)
                    nxt.mode = tfds_pkg::MODE_WAIT_DRAIN;
            end
            tfds_pkg::OP_START_FILL:
            begin
                if (!cur.fill_open)
                begin
                    nxt.fill_open = 1'b1;
                    nxt.fill_time = now_ms;
                    nxt.mode      = tfds_pkg::MODE_FILLING;
                end
            end
            tfds_pkg::OP_START_DRAIN:
            begin
                if (!cur.drain_open)
                begin
                    nxt.drain_open = 1'b1;
                    nxt.drain_time = now_ms;
                    nxt.mode       = tfds_pkg::MODE_DRAINING;
                end
            end
            tfds_pkg::OP_CLEAR:
            begin
                nxt.upper_err = 1'b0;
                nxt.lower_err = 1'b0;
                if (cur.mode == tfds_pkg::MODE_ERR_UPPER ||
                    cur.mode == tfds_pkg::MODE_ERR_LOWER)
                    nxt.mode = tfds_pkg::MODE_RECIRC;
            end
            tfds_pkg::OP_MAN_FILL:
            begin
                nxt.fill_open = valve_on;
                if (valve_on)
                    nxt.fill_time = now_ms;
            end
            tfds_pkg::OP_MAN_DRAIN:
            begin
                nxt.drain_open = valve_on;
                if (valve_on)
                    nxt.drain_time = now_ms;
            end
            default: ; // unused opcodes leave the state alone
        endcase
    end

    // status is taken from the state after the item
    assign blocked      = nxt.upper_err | nxt.lower_err | nxt.fill_open | nxt.drain_open;
    assign hold_elapsed = now_ms - nxt.hold_start;

    always_comb
    begin
        status.mode        = nxt.mode;
        status.fill_valve  = nxt.fill_open;
        status.drain_valve = nxt.drain_open;
        status.upper_error = nxt.upper_err;
        status.lower_error = nxt.lower_err;
        status.wants_fill  = !blocked && !nxt.upper_level &&
                             !(nxt.mode inside {tfds_pkg::MODE_DRAINING,
                                                tfds_pkg::MODE_WAIT_DRAIN,
                                                tfds_pkg::MODE_FILLING});
        status.wants_drain = !blocked && (hold_elapsed >= cfg.hold_time) &&
                             (nxt.mode == tfds_pkg::MODE_HOLDING ||
                              nxt.mode == tfds_pkg::MODE_WAIT_DRAIN);
    end

endmodule

### tb/tank_status_checker.sv
// ----------------------------------------------------------------------------
// tank_status_checker
// watches the item and status channels of the tank fill/drain sequencer,
// predicts each status item from its own copy of the vessel state and
// compares the status items field by field in arrival order
// ----------------------------------------------------------------------------
module tank_status_checker
    import tfds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic        upper_wet,
    input  logic        lower_wet,
    input  logic        valve_on,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  mode,
    input  logic        fill_valve,
    input  logic        drain_valve,
    input  logic        upper_error,
    input  logic        lower_error,
    input  logic        wants_fill,
    input  logic        wants_drain,
    output int          errors,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // settings as last written
    logic [31:0] fill_limit;
    logic [31:0] drain_limit;
    logic [31:0] hold_limit;

    // vessel state
    mode_t       tank_mode;
    logic        fill_on;
    logic        drain_on;
    logic [31:0] fill_t0;
    logic [31:0] drain_t0;
    logic [31:0] hold_t0;
    logic        hi_fault;
    logic        lo_fault;
    logic        hi_wet;
    logic        lo_wet;

    status_t     status_due[$];

    initial errors = 0;
    initial pending = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // one item through the vessel state, status as it stands afterwards
    task automatic step_tank(input logic [3:0] op, input logic [31:0] now,
                             input logic up, input logic lo, input logic von,
                             output status_t st);
        logic [31:0] span;
        logic        faulted;
        case (op)
            OP_LEVELS:
            begin
                hi_wet = up;
                lo_wet = lo;
            end
            OP_SVC_FILL:
            begin
                span = now - fill_t0;
                if (fill_on)
                begin
                    if (hi_wet && lo_wet)
                    begin
                        fill_on   = 1'b0;
                        tank_mode = MODE_HOLDING;
                        hold_t0   = now;
                    end
                    else if (span >= fill_limit && !hi_wet)
                    begin
                        fill_on   = 1'b0;
                        hi_fault  = 1'b1;
                        tank_mode = MODE_ERR_UPPER;
                    end
                end
            end
            OP_SVC_DRAIN:
            begin
                span = now - drain_t0;
                if (drain_on)
                begin
                    if (!hi_wet && !lo_wet)
                    begin
                        drain_on  = 1'b0;
                        tank_mode = MODE_RECIRC;
                    end
                    else if (span >= drain_limit && lo_wet)
                    begin
                        drain_on  = 1'b0;
                        lo_fault  = 1'b1;
                        tank_mode = MODE_ERR_LOWER;
                    end
                end
            end
            OP_IDLE_CHECK:
            begin
                if (!fill_on && !drain_on && !hi_fault && !lo_fault)
                begin
                    // upper wet with lower dry cannot be real
                    if (hi_wet && !lo_wet)
                    begin
                        lo_fault  = 1'b1;
                        tank_mode = MODE_ERR_LOWER;
                    end
                    else if (tank_mode == MODE_RECIRC && hi_wet && lo_wet)
                    begin
                        tank_mode = MODE_HOLDING;
                        hold_t0   = now;
                    end
                end
            end
            OP_QUEUE_FILL:
            begin
                if (tank_mode == MODE_RECIRC || tank_mode == MODE_HOLDING)
                    tank_mode = MODE_WAIT_FILL;
            end
            OP_QUEUE_DRAIN:
            begin
                if (tank_mode == MODE_HOLDING)
                    tank_mode = MODE_WAIT_DRAIN;
            end
            OP_START_FILL:
            begin
                if (!fill_on)
                begin
                    fill_on   = 1'b1;
                    fill_t0   = now;
                    tank_mode = MODE_FILLING;
                end
            end
            OP_START_DRAIN:
            begin
                if (!drain_on)
                begin
                    drain_on  = 1'b1;
                    drain_t0  = now;
                    tank_mode = MODE_DRAINING;
                end
            end
            OP_CLEAR:
            begin
                hi_fault = 1'b0;
                lo_fault = 1'b0;
                if (tank_mode == MODE_ERR_UPPER || tank_mode == MODE_ERR_LOWER)
                    tank_mode = MODE_RECIRC;
            end
            OP_MAN_FILL:
            begin
                fill_on = von;
                if (von)
                    fill_t0 = now;
            end
            OP_MAN_DRAIN:
            begin
                drain_on = von;
                if (von)
                    drain_t0 = now;
            end
            default: ;
        endcase

        faulted        = hi_fault || lo_fault;
        span           = now - hold_t0;
        st.mode        = tank_mode;
        st.fill_valve  = fill_on;
        st.drain_valve = drain_on;
        st.upper_error = hi_fault;
        st.lower_error = lo_fault;
        st.wants_fill  = !faulted && !fill_on && !drain_on && !hi_wet
                         && tank_mode != MODE_DRAINING && tank_mode != MODE_WAIT_DRAIN
                         && tank_mode != MODE_FILLING;
        st.wants_drain = !faulted && !fill_on && !drain_on
                         && (tank_mode == MODE_HOLDING || tank_mode == MODE_WAIT_DRAIN)
                         && span >= hold_limit;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t seen;
        status_t want;
        if (!rst_n)
        begin
            fill_limit  = FILL_TIMEOUT_RST;
            drain_limit = DRAIN_TIMEOUT_RST;
            hold_limit  = HOLD_TIME_RST;
            tank_mode   = MODE_RECIRC;
            fill_on     = 1'b0;
            drain_on    = 1'b0;
            fill_t0     = '0;
            drain_t0    = '0;
            hold_t0     = '0;
            hi_fault    = 1'b0;
            lo_fault    = 1'b0;
            hi_wet      = 1'b0;
            lo_wet      = 1'b0;
            status_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILL_TIMEOUT:  fill_limit  = cfg_data;
                    CFG_DRAIN_TIMEOUT: drain_limit = cfg_data;
                    CFG_HOLD_TIME:     hold_limit  = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                    flag_mismatch("status item with none expected", 32'(mode), '0);
                else
                begin
                    want = status_due.pop_front();
                    if (mode !== want.mode)
                        flag_mismatch("mode", 32'(mode), 32'(want.mode));
                    if (fill_valve !== want.fill_valve)
                        flag_mismatch("fill_valve", 32'(fill_valve), 32'(want.fill_valve));
                    if (drain_valve !== want.drain_valve)
                        flag_mismatch("drain_valve", 32'(drain_valve),
                                      32'(want.drain_valve));
                    if (upper_error !== want.upper_error)
                        flag_mismatch("upper_error", 32'(upper_error),
                                      32'(want.upper_error));
                    if (lower_error !== want.lower_error)
                        flag_mismatch("lower_error", 32'(lower_error),
                                      32'(want.lower_error));
                    if (wants_fill !== want.wants_fill)
                        flag_mismatch("wants_fill", 32'(wants_fill), 32'(want.wants_fill));
                    if (wants_drain !== want.wants_drain)
                        flag_mismatch("wants_drain", 32'(wants_drain),
                                      32'(want.wants_drain));
                end
            end

            if (in_valid && !in_stall)
            begin
                step_tank(opcode, now_ms, upper_wet, lower_wet, valve_on, seen);
                status_due.push_back(seen);
            end
        end
        pending = status_due.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for the tank fill/drain sequencer: a directed run of corner items
// at the reset settings, then random fill/drain sequences and noise under
// several register settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tfds_pkg::*;

    // register index that decodes to nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // first and last of the spare opcodes, which change nothing
    localparam logic [3:0] OP_SPARE_FIRST = 4'd11;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  opcode;
    logic [31:0] now_ms;
    logic        upper_wet;
    logic        lower_wet;
    logic        valve_on;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  mode;
    logic        fill_valve;
    logic        drain_valve;
    logic        upper_error;
    logic        lower_error;
    logic        wants_fill;
    logic        wants_drain;

    int          errors;
    int          pending;

    // stimulus side bookkeeping
    logic [31:0] clock_ms;      // running millisecond clock for random items
    int          phase_items;
    bit          calm;          // no idling on either side while set
    bit          burst_go;      // asks the receiver for its long hold-off
    bit          burst_done;

    tank_fill_drain_sequencer_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .now_ms      (now_ms),
        .upper_wet   (upper_wet),
        .lower_wet   (lower_wet),
        .valve_on    (valve_on),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mode        (mode),
        .fill_valve  (fill_valve),
        .drain_valve (drain_valve),
        .upper_error (upper_error),
        .lower_error (lower_error),
        .wants_fill  (wants_fill),
        .wants_drain (wants_drain)
    );

    tank_status_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .now_ms      (now_ms),
        .upper_wet   (upper_wet),
        .lower_wet   (lower_wet),
        .valve_on    (valve_on),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mode        (mode),
        .fill_valve  (fill_valve),
        .drain_valve (drain_valve),
        .upper_error (upper_error),
        .lower_error (lower_error),
        .wants_fill  (wants_fill),
        .wants_drain (wants_drain),
        .errors      (errors),
        .pending     (pending)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #(2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // status receiver: random stalls, one long hold-off so the block backs up
    initial
    begin
        out_stall  = 1'b0;
        burst_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst_go && !burst_done)
            begin
                out_stall <= 1'b1;
                // hold-off counted here while the sender keeps offering items
                repeat (80) @(negedge clk);
                burst_done = 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    function bit rb();
        return 1'($urandom_range(1));
    endfunction

    // advance the millisecond clock: mostly short steps, some long, a few wraps
    function logic [31:0] tick();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            clock_ms += $urandom_range(50);
        else if (pick < 92)
            clock_ms += $urandom_range(400000);
        else
            clock_ms += $urandom;
        return clock_ms;
    endfunction

    // offer one item, entered and left at a falling edge, valid left high
    task automatic send_item(input logic [3:0] op, input logic [31:0] now,
                             input logic up, input logic lo, input logic von);
        while (!calm && ($urandom_range(99) < 24))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        now_ms    <= now;
        upper_wet <= up;
        lower_wet <= lo;
        valve_on  <= von;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        phase_items++;
    endtask

    task automatic send_op(input logic [3:0] op, input logic up, input logic lo,
                           input logic von);
        send_item(op, tick(), up, lo, von);
    endtask

    // channel quiet and every status item back before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs(input logic [31:0] fill_lim, input logic [31:0] drain_lim,
                                input logic [31:0] hold_lim, input bit stray);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FILL_TIMEOUT;
        cfg_data  <= fill_lim;
        @(negedge clk);
        cfg_index <= CFG_DRAIN_TIMEOUT;
        cfg_data  <= drain_lim;
        @(negedge clk);
        cfg_index <= CFG_HOLD_TIME;
        cfg_data  <= hold_lim;
        @(negedge clk);
        if (stray)
        begin
            // write to an index past the last register must change nothing
            cfg_index <= CFG_UNUSED;
            cfg_data  <= $urandom;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // one fill, hold and drain round with random timing and detours
    task automatic tank_round();
        if (rb())
            send_op(OP_LEVELS, 1'b0, 1'b0, rb());
        if (rb())
            send_op(OP_IDLE_CHECK, rb(), rb(), rb());
        send_op(OP_QUEUE_FILL, rb(), rb(), rb());
        send_op(OP_START_FILL, rb(), rb(), rb());
        repeat ($urandom_range(3))
            send_op(OP_SVC_FILL, rb(), rb(), rb());
        if ($urandom_range(3) != 0)
        begin
            // lower switch wets first, then upper
            send_op(OP_LEVELS, 1'b0, 1'b1, rb());
            send_op(OP_SVC_FILL, rb(), rb(), rb());
            send_op(OP_LEVELS, 1'b1, 1'b1, rb());
            send_op(OP_SVC_FILL, rb(), rb(), rb());
        end
        else
            send_op(OP_SVC_FILL, rb(), rb(), rb());
        if ($urandom_range(4) == 0)
            send_op(OP_IDLE_CHECK, rb(), rb(), rb());
        send_op(OP_QUEUE_DRAIN, rb(), rb(), rb());
        repeat ($urandom_range(2))
            send_op(OP_LEVELS, 1'b1, 1'b1, rb());
        send_op(OP_START_DRAIN, rb(), rb(), rb());
        repeat ($urandom_range(2))
            send_op(OP_SVC_DRAIN, rb(), rb(), rb());
        if ($urandom_range(3) != 0)
        begin
            send_op(OP_LEVELS, 1'b0, 1'b1, rb());
            send_op(OP_SVC_DRAIN, rb(), rb(), rb());
            send_op(OP_LEVELS, 1'b0, 1'b0, rb());
            send_op(OP_SVC_DRAIN, rb(), rb(), rb());
        end
        else
            send_op(OP_SVC_DRAIN, rb(), rb(), rb());
        if (rb())
            send_op(OP_CLEAR, rb(), rb(), rb());
        if ($urandom_range(4) == 0)
            send_op(rb() ? OP_MAN_FILL : OP_MAN_DRAIN, rb(), rb(), rb());
    endtask

    initial
    begin
        logic [31:0] lim_fill;
        logic [31:0] lim_drain;
        logic [31:0] lim_hold;

        // every input known from time zero
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FILL_TIMEOUT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        opcode    = OP_LEVELS;
        now_ms    = '0;
        upper_wet = 1'b0;
        lower_wet = 1'b0;
        valve_on  = 1'b0;
        clock_ms  = '0;
        calm      = 1'b0;
        burst_go  = 1'b0;
        phase_items = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners at the reset settings
        send_item(OP_SPARE_LAST, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1); // unused opcode
        send_item(OP_SVC_FILL, 32'd0, 1'b0, 1'b0, 1'b0);        // service, valve shut
        send_item(OP_SVC_DRAIN, 32'd0, 1'b0, 1'b0, 1'b0);
        send_item(OP_LEVELS, 32'd10, 1'b1, 1'b0, 1'b0);
        send_item(OP_IDLE_CHECK, 32'd20, 1'b0, 1'b0, 1'b0);     // inconsistent switches
        send_item(OP_QUEUE_FILL, 32'd30, 1'b0, 1'b0, 1'b0);     // blocked by error
        send_item(OP_CLEAR, 32'd40, 1'b0, 1'b0, 1'b0);
        send_item(OP_LEVELS, 32'd50, 1'b1, 1'b1, 1'b0);
        send_item(OP_IDLE_CHECK, 32'd100, 1'b0, 1'b0, 1'b0);    // recirc full, holds
        send_item(OP_QUEUE_DRAIN, 32'd200, 1'b0, 1'b0, 1'b0);   // hold not elapsed
        send_item(OP_LEVELS, 32'd300100, 1'b1, 1'b1, 1'b0);     // hold just elapsed
        send_item(OP_START_DRAIN, 32'd300200, 1'b0, 1'b0, 1'b0);
        send_item(OP_START_DRAIN, 32'd300300, 1'b0, 1'b0, 1'b0); // already open
        send_item(OP_SVC_DRAIN, 32'd360200, 1'b0, 1'b0, 1'b0);  // drain timeout
        send_item(OP_CLEAR, 32'd360300, 1'b0, 1'b0, 1'b0);
        send_item(OP_LEVELS, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0);
        send_item(OP_START_FILL, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0);
        send_item(OP_SVC_FILL, 32'h0000_EA00, 1'b0, 1'b0, 1'b0); // timeout across wrap
        send_item(OP_CLEAR, 32'h0000_EB00, 1'b0, 1'b0, 1'b0);
        send_item(OP_MAN_FILL, 32'd5, 1'b0, 1'b0, 1'b1);
        send_item(OP_MAN_FILL, 32'd6, 1'b0, 1'b0, 1'b0);        // closing keeps stamp
        send_item(OP_MAN_DRAIN, 32'd7, 1'b0, 1'b0, 1'b1);
        send_item(OP_MAN_DRAIN, 32'd8, 1'b0, 1'b0, 1'b0);
        send_item(OP_SPARE_FIRST, 32'd9, 1'b1, 1'b0, 1'b1);
        send_item(OP_QUEUE_FILL, 32'd10, 1'b0, 1'b0, 1'b0);

        // random phases, one register setting each
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:       begin lim_fill = 32'd40; lim_drain = 32'd40; lim_hold = 32'd100; end
                1:       begin lim_fill = '0; lim_drain = '0; lim_hold = '0; end
                2:       begin lim_fill = '1; lim_drain = '1; lim_hold = '1; end
                3:
                begin
                    lim_fill  = $urandom_range(300);
                    lim_drain = $urandom_range(300);
                    lim_hold  = $urandom_range(500);
                end
                default: begin lim_fill = 32'd60000; lim_drain = 32'd60000; lim_hold = 32'd300000; end
            endcase
            program_regs(lim_fill, lim_drain, lim_hold, ph == 0 || ph == 3);
            burst_go    = (ph == 1);
            calm        = (ph == 2);
            phase_items = 0;
            while (phase_items < 80)
            begin
                if ($urandom_range(3) != 0)
                    tank_round();
                else
                begin
                    // noise: any opcode, any fields
                    repeat ($urandom_range(1, 4))
                        send_item(4'($urandom_range(15)), rb() ? tick() : $urandom,
                                  rb(), rb(), rb());
                end
            end
        end
        calm = 1'b0;

        // drain out and give the pipeline time to show anything stray
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
